// ===== src/two_pool_stack_allocator_assert.svh =====
// Assertion macros used by the allocator's checker file.
`ifndef TWO_POOL_STACK_ALLOCATOR_ASSERT_SVH
`define TWO_POOL_STACK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define TSPA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("two_pool_stack_allocator: same-cycle check failed");

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define TSPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("two_pool_stack_allocator: next-cycle check failed");

`endif

// ===== src/tspa_pkg.sv =====
// Types, constants and codes shared by the two-pool stack allocator.
package tspa_pkg;

  localparam int TOP_W       = 21;
  localparam int ELEM_W      = 7;
  localparam int POOL_W      = 2;
  localparam int STATUS_W    = 3;
  localparam int SIZE_W      = TOP_W + ELEM_W;
  localparam int END_W       = SIZE_W + 1;
  localparam int ALIGN_BYTES = 64;
  localparam int POOL_BYTES  = 1048576;
  localparam int ALIGN_LOG2  = $clog2(ALIGN_BYTES);

  localparam logic [TOP_W:0] ALIGN_MASK = (TOP_W + 1)'(ALIGN_BYTES - 1);
  localparam logic [END_W-1:0] POOL_LIMIT = END_W'(POOL_BYTES);

  typedef logic [TOP_W-1:0] top_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [POOL_W-1:0] {
    POOL_SEND  = 2'd0,
    POOL_RECV  = 2'd1,
    POOL_BAD_A = 2'd2,
    POOL_BAD_B = 2'd3
  } pool_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_OVERFLOW = 3'd1,
    ST_ORDER    = 3'd2,
    ST_BADPOOL  = 3'd3,
    ST_IGNORED  = 3'd4
  } status_t;

  typedef struct packed {
    op_t               operation;
    pool_t             pool;
    top_t              count;
    logic [ELEM_W-1:0] elem_size;
    top_t              block_offset;
    top_t              block_size;
    logic              handle_live;
  } req_t;

  typedef struct packed {
    status_t status;
    top_t    granted_offset;
    top_t    granted_size;
  } res_t;

  typedef struct packed {
    logic we_send;
    logic we_recv;
    top_t top_val;
  } upd_t;

endpackage

// ===== src/tspa_req_if.sv =====
// Request channel: valid, ready and the fields of one request item.
interface tspa_req_if;
  import tspa_pkg::*;

  logic              valid;
  logic              ready;
  logic              operation;
  logic [POOL_W-1:0] pool;
  top_t              count;
  logic [ELEM_W-1:0] elem_size;
  top_t              block_offset;
  top_t              block_size;
  logic              handle_live;

  modport source (
    output valid, operation, pool, count, elem_size, block_offset, block_size,
           handle_live,
    input  ready
  );

  modport sink (
    input  valid, operation, pool, count, elem_size, block_offset, block_size,
           handle_live,
    output ready
  );

  modport mon (
    input valid, ready, operation, pool, count, elem_size, block_offset,
          block_size, handle_live
  );
endinterface

// ===== src/tspa_res_if.sv =====
// Result channel: valid, ready and the fields of one result item.
interface tspa_res_if;
  import tspa_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  top_t                granted_offset;
  top_t                granted_size;

  modport source (
    output valid, status, granted_offset, granted_size,
    input  ready
  );

  modport sink (
    input  valid, status, granted_offset, granted_size,
    output ready
  );

  modport mon (
    input valid, ready, status, granted_offset, granted_size
  );
endinterface

// ===== src/tspa_datapath.sv =====
// Decision logic for one request: alignment, size product, pool, fit and order checks.
module tspa_datapath (
  input  tspa_pkg::req_t req,
  input  tspa_pkg::top_t send_top,
  input  tspa_pkg::top_t recv_top,
  output tspa_pkg::res_t res,
  output tspa_pkg::upd_t upd
);
  import tspa_pkg::*;

  top_t              cur_top;
  logic              pool_ok;
  logic [SIZE_W-1:0] size;
  logic [TOP_W:0]    round_sum;
  logic [TOP_W:0]    aligned;
  logic [END_W-1:0]  alloc_end;
  logic              fits;
  logic [TOP_W:0]    free_end;
  logic              order_ok;
  logic              write_top;

  always_comb begin
    pool_ok = (req.pool == POOL_SEND) || (req.pool == POOL_RECV);
    cur_top = (req.pool == POOL_SEND) ? send_top : recv_top;

    size      = SIZE_W'(req.count) * SIZE_W'(req.elem_size);
    round_sum = {1'b0, cur_top} + ALIGN_MASK;
    aligned   = round_sum & ~ALIGN_MASK;
    alloc_end = END_W'(aligned) + END_W'(size);
    fits      = (alloc_end <= POOL_LIMIT);

    free_end = {1'b0, req.block_offset} + {1'b0, req.block_size};
    order_ok = (free_end == {1'b0, cur_top});

    res.status         = ST_OK;
    res.granted_offset = '0;
    res.granted_size   = '0;
    write_top          = 1'b0;
    upd.top_val        = req.block_offset;

    if (req.operation == OP_ALLOC) begin
      upd.top_val = alloc_end[TOP_W-1:0];
      if (!pool_ok) begin
        res.status = ST_BADPOOL;
      end else if (!fits) begin
        res.status = ST_OVERFLOW;
      end else begin
        res.granted_offset = aligned[TOP_W-1:0];
        res.granted_size   = size[TOP_W-1:0];
        write_top          = 1'b1;
      end
    end else begin
      if (!req.handle_live) begin
        res.status = ST_IGNORED;
      end else if (!pool_ok) begin
        res.status = ST_BADPOOL;
      end else if (!order_ok) begin
        res.status = ST_ORDER;
      end else begin
        write_top = 1'b1;
      end
    end

    upd.we_send = write_top && (req.pool == POOL_SEND);
    upd.we_recv = write_top && (req.pool == POOL_RECV);
  end
endmodule

// ===== src/two_pool_stack_allocator.sv =====
// Top level of the two-pool stack allocator: request register, pool tops, result register.
//
//   channel  | modport | direction | fields
//   ---------+---------+-----------+------------------------------------------------
//   in_req   | sink    | in        | operation pool count elem_size block_offset
//            |         |           | block_size handle_live
//   out_res  | source  | out       | status granted_offset granted_size
//
// One item per cycle sustained while the result channel is not stalled; each item passes
// from acceptance to its result through the request register and then the result register.
// The pool tops are written at the edge at which an item moves into the result
// register, so the item behind it always sees the updated tops.
// rst_n (synchronous, active low) clears both tops and both valid flags.
// A stalled result holds; requests keep flowing until both registers are full.
module two_pool_stack_allocator (
  input logic         clk,
  input logic         rst_n,
  tspa_req_if.sink    in_req,
  tspa_res_if.source  out_res
);
  import tspa_pkg::*;

  logic s1_valid_r;
  logic s1_valid_nxt;
  req_t s1_req_r;
  req_t s1_req_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  res_t out_res_r;
  res_t out_res_nxt;
  top_t send_top_r;
  top_t send_top_nxt;
  top_t recv_top_r;
  top_t recv_top_nxt;

  logic out_adv;
  logic s1_adv;
  logic in_take;
  req_t in_item;
  res_t dp_res;
  upd_t dp_upd;

  tspa_datapath u_datapath (
    .req      (s1_req_r),
    .send_top (send_top_r),
    .recv_top (recv_top_r),
    .res      (dp_res),
    .upd      (dp_upd)
  );

  always_comb begin
    in_item.operation    = op_t'(in_req.operation);
    in_item.pool         = pool_t'(in_req.pool);
    in_item.count        = in_req.count;
    in_item.elem_size    = in_req.elem_size;
    in_item.block_offset = in_req.block_offset;
    in_item.block_size   = in_req.block_size;
    in_item.handle_live  = in_req.handle_live;

    out_adv = !out_valid_r || out_res.ready;
    s1_adv  = s1_valid_r && out_adv;
    in_take = in_req.valid && (!s1_valid_r || out_adv);

    s1_valid_nxt = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    s1_req_nxt   = in_take ? in_item : s1_req_r;

    out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;
    out_res_nxt   = s1_adv ? dp_res : out_res_r;

    send_top_nxt = (s1_adv && dp_upd.we_send) ? dp_upd.top_val : send_top_r;
    recv_top_nxt = (s1_adv && dp_upd.we_recv) ? dp_upd.top_val : recv_top_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      send_top_r  <= '0;
      recv_top_r  <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      send_top_r  <= send_top_nxt;
      recv_top_r  <= recv_top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_req_r  <= s1_req_nxt;
    out_res_r <= out_res_nxt;
  end

  assign in_req.ready           = !s1_valid_r || out_adv;
  assign out_res.valid          = out_valid_r;
  assign out_res.status         = out_res_r.status;
  assign out_res.granted_offset = out_res_r.granted_offset;
  assign out_res.granted_size   = out_res_r.granted_size;
endmodule

// ===== src/tspa_checker.sv =====
// Port-level checks on the allocator's result channel, bound to the top level.
`include "two_pool_stack_allocator_assert.svh"

module tspa_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tspa_pkg::STATUS_W-1:0] out_status,
  input tspa_pkg::top_t                out_granted_offset,
  input tspa_pkg::top_t                out_granted_size
);
  import tspa_pkg::*;

  logic [TOP_W:0]                grant_end;
  logic                          out_ok;
  logic                          out_fail;
  logic                          out_hold;
  logic                          fields_zero;
  logic                          off_aligned;
  logic [STATUS_W+2*TOP_W-1:0]   out_word;

  assign grant_end   = {1'b0, out_granted_offset} + {1'b0, out_granted_size};
  assign out_ok      = out_valid && (out_status == ST_OK);
  assign out_fail    = out_valid && (out_status != ST_OK);
  assign out_hold    = out_valid && !out_ready;
  assign fields_zero = (out_granted_offset == '0) && (out_granted_size == '0);
  assign off_aligned = (out_granted_offset & ALIGN_MASK[TOP_W-1:0]) == '0;
  assign out_word    = {out_status, out_granted_offset, out_granted_size};

  `TSPA_ASSERT_NOW(a_fail_fields_zero, out_fail, fields_zero)
  `TSPA_ASSERT_NOW(a_offset_aligned, out_valid, off_aligned)
  `TSPA_ASSERT_NOW(a_grant_in_pool, out_ok, grant_end <= (TOP_W + 1)'(POOL_BYTES))
  `TSPA_ASSERT_NEXT(a_result_holds, out_hold, out_valid && $stable(out_word))
endmodule

bind two_pool_stack_allocator tspa_checker u_tspa_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_res.valid),
  .out_ready          (out_res.ready),
  .out_status         (out_res.status),
  .out_granted_offset (out_res.granted_offset),
  .out_granted_size   (out_res.granted_size)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the two-pool stack allocator: directed and random requests.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tspa_pkg::*;

  localparam int CYCLE_LIMIT  = 250000;
  localparam int RANDOM_ITEMS = 1150;
  localparam int LONG_HOLD    = 300;
  localparam int BURST_ITEMS  = 40;
  localparam int TAIL_CYCLES  = 8;

  typedef struct {
    top_t off;
    top_t len;
  } block_t;

  class stack_grant_checker;
    longint unsigned send_top = 0;
    longint unsigned recv_top = 0;
    res_t            expected_grants[$];
    int              failures = 0;

    function longint unsigned top_of(pool_t p);
      return (p == POOL_RECV) ? recv_top : send_top;
    endfunction

    function int outstanding();
      return expected_grants.size();
    endfunction

    function res_t note_request(req_t r);
      res_t            g;
      longint unsigned top;
      longint unsigned aligned;
      longint unsigned span;
      logic            pool_ok;
      g.status         = ST_OK;
      g.granted_offset = '0;
      g.granted_size   = '0;
      pool_ok = (r.pool == POOL_SEND) || (r.pool == POOL_RECV);
      top     = top_of(r.pool);
      if (r.operation == OP_ALLOC) begin
        if (!pool_ok) begin
          g.status = ST_BADPOOL;
        end else begin
          span    = r.count;
          span    = span * r.elem_size;
          aligned = (top + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
          if (aligned + span > POOL_BYTES) begin
            g.status = ST_OVERFLOW;
          end else begin
            g.granted_offset = top_t'(aligned);
            g.granted_size   = top_t'(span);
            top              = aligned + span;
          end
        end
      end else if (!r.handle_live) begin
        g.status = ST_IGNORED;
      end else if (!pool_ok) begin
        g.status = ST_BADPOOL;
      end else if (r.block_offset + r.block_size != top) begin
        g.status = ST_ORDER;
      end else begin
        top = r.block_offset;
      end
      if (r.pool == POOL_SEND) begin
        send_top = top;
      end else if (r.pool == POOL_RECV) begin
        recv_top = top;
      end
      expected_grants.push_back(g);
      return g;
    endfunction

    function void check_grant(logic [STATUS_W-1:0] st, top_t off, top_t len);
      res_t want;
      if (expected_grants.size() == 0) begin
        failures++;
        $error("result item with no request outstanding: status %0d", st);
        return;
      end
      want = expected_grants.pop_front();
      if (st !== want.status) begin
        failures++;
        $error("status: expected %0d, got %0d", want.status, st);
      end
      if (off !== want.granted_offset) begin
        failures++;
        $error("granted_offset: expected %0d, got %0d", want.granted_offset, off);
      end
      if (len !== want.granted_size) begin
        failures++;
        $error("granted_size: expected %0d, got %0d", want.granted_size, len);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  tspa_req_if req_ch ();
  tspa_res_if res_ch ();

  two_pool_stack_allocator dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_res (res_ch)
  );

  stack_grant_checker grants = new();
  block_t             live_blocks[2][$];
  bit                 no_idle = 1'b0;
  bit                 long_hold_req = 1'b0;
  int                 cycle_count = 0;

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      grants.check_grant(res_ch.status, res_ch.granted_offset, res_ch.granted_size);
    end
  end

  function automatic req_t mk_req(op_t op, pool_t p, int unsigned cnt, int unsigned es,
                                  int unsigned boff, int unsigned bsz, bit live);
    req_t r;
    r.operation    = op;
    r.pool         = p;
    r.count        = top_t'(cnt);
    r.elem_size    = 7'(es);
    r.block_offset = top_t'(boff);
    r.block_size   = top_t'(bsz);
    r.handle_live  = live;
    return r;
  endfunction

  task automatic issue(input req_t r);
    int   gap;
    int   pi;
    res_t g;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.operation    <= r.operation;
    req_ch.pool         <= r.pool;
    req_ch.count        <= r.count;
    req_ch.elem_size    <= r.elem_size;
    req_ch.block_offset <= r.block_offset;
    req_ch.block_size   <= r.block_size;
    req_ch.handle_live  <= r.handle_live;
    do @(posedge clk); while (!req_ch.ready);
    g  = grants.note_request(r);
    pi = r.pool[0];
    if (g.status == ST_OK && r.operation == OP_ALLOC) begin
      live_blocks[pi].push_back('{g.granted_offset, g.granted_size});
    end else if (g.status == ST_OK) begin
      while (live_blocks[pi].size() > 0 &&
             int'(live_blocks[pi][$].off) + int'(live_blocks[pi][$].len) >
             int'(r.block_offset)) begin
        void'(live_blocks[pi].pop_back());
      end
    end
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (grants.outstanding() != 0);
  endtask

  initial begin
    int stall;
    res_ch.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        stall         = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 7);
      end
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  initial begin
    req_t            r;
    logic [95:0]     noise;
    pool_t           p;
    int              pi;
    int              pick;
    int              useful;
    int              issued;
    int              burst_left;
    int unsigned     es;
    longint unsigned top;
    longint unsigned aligned;
    longint unsigned remaining;
    rst_n               = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.operation    = 1'b0;
    req_ch.pool         = '0;
    req_ch.count        = '0;
    req_ch.elem_size    = '0;
    req_ch.block_offset = '0;
    req_ch.block_size   = '0;
    req_ch.handle_live  = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    issue(mk_req(OP_ALLOC, POOL_SEND, 0, 1, 21'h1FFFFF, 21'h1FFFFF, 1'b1));
    issue(mk_req(OP_ALLOC, POOL_SEND, 3, 5, 0, 0, 1'b0));
    issue(mk_req(OP_ALLOC, POOL_SEND, 0, 64, 0, 0, 1'b0));
    issue(mk_req(OP_ALLOC, POOL_SEND, 1, 64, 0, 0, 1'b0));
    issue(mk_req(OP_FREE, POOL_SEND, 21'h1FFFFF, 127, 0, 15, 1'b1));
    issue(mk_req(OP_FREE, POOL_SEND, 0, 0, 64, 64, 1'b0));
    issue(mk_req(OP_FREE, POOL_SEND, 21'h1FFFFF, 127, 64, 64, 1'b1));
    issue(mk_req(OP_ALLOC, POOL_RECV, POOL_BYTES, 1, 0, 0, 1'b0));
    issue(mk_req(OP_ALLOC, POOL_RECV, 0, 1, 0, 0, 1'b0));
    issue(mk_req(OP_ALLOC, POOL_RECV, 1, 1, 0, 0, 1'b0));
    issue(mk_req(OP_ALLOC, POOL_SEND, 21'h1FFFFF, 127, 0, 0, 1'b0));
    issue(mk_req(OP_ALLOC, POOL_SEND, 16383, 64, 0, 0, 1'b0));
    issue(mk_req(OP_FREE, POOL_RECV, 0, 1, 0, POOL_BYTES, 1'b1));
    issue(mk_req(OP_FREE, POOL_SEND, 0, 1, 21'h1FFFFF, 21'h1FFFFF, 1'b1));
    issue(mk_req(OP_ALLOC, POOL_BAD_A, 1, 1, 0, 0, 1'b1));
    issue(mk_req(OP_ALLOC, POOL_BAD_B, 21'h1FFFFF, 127, 0, 0, 1'b0));
    issue(mk_req(OP_FREE, POOL_BAD_A, 0, 0, 0, 0, 1'b1));
    issue(mk_req(OP_FREE, POOL_BAD_B, 0, 0, 0, 0, 1'b0));
    issue(mk_req(OP_FREE, POOL_SEND, 0, 0, 0, POOL_BYTES, 1'b1));
    issue(mk_req(OP_ALLOC, POOL_SEND, 1, 0, 0, 0, 1'b0));
    drain_results();

    useful     = 0;
    issued     = 0;
    burst_left = 0;
    while (useful < RANDOM_ITEMS) begin
      if (issued == 500) begin
        long_hold_req = 1'b1;
        burst_left    = BURST_ITEMS;
      end
      if (burst_left > 0) begin
        no_idle = 1'b1;
      end else if (issued % 120 == 0) begin
        no_idle = ($urandom_range(0, 2) == 0);
      end
      noise = {$urandom, $urandom, $urandom};
      r     = noise[$bits(req_t)-1:0];
      p     = pool_t'($urandom_range(0, 1));
      pi    = p;
      top   = grants.top_of(p);
      pick  = $urandom_range(0, 99);
      if (pick < 40) begin
        r.operation = OP_ALLOC;
        r.pool      = p;
        r.count     = top_t'($urandom_range(0, 300));
        r.elem_size = 7'($urandom_range(1, 64));
      end else if (pick < 70) begin
        r.operation   = OP_FREE;
        r.pool        = p;
        r.handle_live = 1'b1;
        if (live_blocks[pi].size() > 0) begin
          r.block_offset = live_blocks[pi][$].off;
          r.block_size   = top_t'(top - live_blocks[pi][$].off);
        end else begin
          r.block_offset = '0;
          r.block_size   = top_t'(top);
        end
      end else if (pick < 75) begin
        r.operation    = OP_FREE;
        r.pool         = p;
        r.handle_live  = 1'b1;
        r.block_offset = top_t'($urandom_range(0, int'(top)));
        r.block_size   = top_t'(top - r.block_offset);
      end else if (pick < 80) begin
        r.operation = OP_ALLOC;
        r.pool      = p;
      end else if (pick < 85) begin
        r.operation   = OP_FREE;
        r.pool        = p;
        r.handle_live = 1'b1;
      end else if (pick < 90) begin
        r.operation   = OP_FREE;
        r.handle_live = 1'b0;
      end else if (pick < 95) begin
        r.pool = pool_t'($urandom_range(2, 3));
      end else if (pick < 98) begin
        aligned     = (top + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
        remaining   = POOL_BYTES - aligned;
        es          = $urandom_range(0, 1) ? 1 : $urandom_range(1, 64);
        r.operation = OP_ALLOC;
        r.pool      = p;
        r.elem_size = 7'(es);
        r.count     = top_t'(remaining / es + $urandom_range(0, 1));
      end else begin
        r.operation = OP_ALLOC;
        r.pool      = p;
        r.count     = '0;
      end
      issue(r);
      issued++;
      if (!(r.operation == OP_FREE && !r.handle_live)) begin
        useful++;
      end
      if (burst_left > 0) begin
        burst_left--;
        if (burst_left == 0) begin
          no_idle = 1'b0;
          drain_results();
        end
      end else if ($urandom_range(0, 99) == 0) begin
        drain_results();
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (grants.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+src
src/tspa_pkg.sv
src/tspa_req_if.sv
src/tspa_res_if.sv
src/tspa_datapath.sv
src/two_pool_stack_allocator.sv
src/tspa_checker.sv
verif/tb_top.sv
